>>> sv/bpf_pkg.sv
`default_nettype none

package bpf_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int POS_BITS    = 32;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int OFFSET_W    = 16;
    localparam int PATCH_W     = 34;
    localparam int COUNT_W     = 8;
    localparam int START_W     = 32;

    localparam int OUT_FIELDS_W = START_W + PATCH_W + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATCH_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES  = 3'd4;

    typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] t_window;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_beat;

endpackage

`default_nettype wire

>>> sv/byte_pattern_find_for_patch_core.sv
`default_nettype none
// Byte pattern search for patching.
// The slave stream carries the searched buffer, one byte per beat in tdata,
// with tlast on the final byte. The master stream carries one result beat for
// every byte that completes a match within the match limit and one for the
// final byte of a buffer. A match on the final byte gives a single beat with
// tuser and tlast both set; other non-final byte beats give no result beat.
// Each byte passes an input register and then one compare stage that writes
// the result register. A byte is accepted in every cycle while results are
// taken; the window compare of all pattern bytes is done in parallel in that
// stage. When the result register is full and the receiver stalls, one more
// byte is held in the input register and tready then drops until the result
// is taken. Reset clears the byte window, the position and match counters,
// and loads the register defaults: a one-byte zero pattern, zero offset and
// a limit of one match. Registers must be written only while the block is
// idle; the block itself does not enforce this.
module byte_pattern_find_for_patch_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bpf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bpf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // Fields from bit 0: data_byte.
    input  wire logic [7:0]                          s_axis_tdata,
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // Fields from bit 0: match_start, patch_address, match_number, zero fill.
    output logic [bpf_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // Fields from bit 0: match_found.
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast
);
    import bpf_pkg::*;

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_pat_len;
    logic [OFFSET_W-1:0]   r_offset;
    logic [COUNT_W-1:0]    r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
            r_offset  <= '0;
            r_max     <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pat_lo  <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pat_hi  <= i_cfg_data;
                CFG_PATTERN_LEN:  r_pat_len <= i_cfg_data[LEN_W-1:0];
                CFG_PATCH_OFFSET: r_offset  <= i_cfg_data[OFFSET_W-1:0];
                CFG_MAX_MATCHES:  r_max     <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] len;
    t_window          pattern;
    logic [2*CFG_DATA_W-1:0] pat_all;

    assign pat_all = {r_pat_hi, r_pat_lo};
    assign pattern = t_window'(pat_all[PATTERN_MAX*BYTE_W-1:0]);

    always_comb begin
        if (r_pat_len == '0) begin
            len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(PATTERN_MAX)) begin
            len = LEN_W'(PATTERN_MAX);
        end else begin
            len = r_pat_len;
        end
    end

    t_in_beat in_beat;
    t_in_beat cur;
    logic     cur_valid;
    logic     out_free;
    logic     step;
    logic     equal;

    assign in_beat.data_byte = s_axis_tdata;
    assign in_beat.last_byte = s_axis_tlast;

    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign step     = cur_valid && out_free;

    bpf_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_beat        (in_beat),
        .i_take        (step),
        .o_valid       (cur_valid),
        .o_beat        (cur)
    );

    bpf_match u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (cur.data_byte),
        .i_pattern (pattern),
        .i_len     (len),
        .o_equal   (equal)
    );

    logic [POS_BITS-1:0] r_pos;
    logic [LEN_W-1:0]    r_since;
    logic [COUNT_W-1:0]  r_count;

    logic [LEN_W-1:0]    avail;
    logic                hit;
    logic [COUNT_W-1:0]  count_inc;
    logic [POS_BITS-1:0] start;
    logic [PATCH_W-1:0]  patch;

    assign avail = (r_since >= LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                    : r_since + LEN_W'(1);
    assign hit       = (avail >= len) && (r_count < r_max) && equal;
    assign count_inc = r_count + COUNT_W'(1);
    assign start     = r_pos - POS_BITS'(len - LEN_W'(1));
    assign patch     = PATCH_W'(start) + {{(PATCH_W-OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_since <= '0;
            r_count <= '0;
        end else if (step) begin
            if (cur.last_byte) begin
                r_pos   <= '0;
                r_since <= '0;
                r_count <= '0;
            end else begin
                r_pos   <= r_pos + POS_BITS'(1);
                r_since <= hit ? '0 : avail;
                r_count <= hit ? count_inc : r_count;
            end
        end
    end

    logic                r_out_valid;
    logic                r_found;
    logic [START_W-1:0]  r_start;
    logic [PATCH_W-1:0]  r_patch;
    logic [COUNT_W-1:0]  r_number;
    logic                r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && (hit || cur.last_byte)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && (hit || cur.last_byte)) begin
            r_found  <= hit;
            r_start  <= hit ? START_W'(start) : '0;
            r_patch  <= hit ? patch : '0;
            r_number <= hit ? count_inc : r_count;
            r_end    <= cur.last_byte;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_found;
    assign m_axis_tlast  = r_end;
    assign m_axis_tdata  = OUT_TDATA_W'({r_number, r_patch, r_start});

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_since <= LEN_W'(PATTERN_MAX))
        else $error("bytes since match above window depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
        else $error("result beat without match or buffer end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (r_start == '0 && r_patch == '0))
        else $error("end beat without match carries a position");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_number != '0))
        else $error("match beat with zero match number");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && cur.last_byte) |=> (r_pos == '0 && r_count == '0 && r_since == '0))
        else $error("buffer state not cleared after final byte");

endmodule

`default_nettype wire

>>> sv/bpf_in_stage.sv
`default_nettype none

module bpf_in_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire bpf_pkg::t_in_beat i_beat,
    input  wire logic             i_take,
    output logic                  o_valid,
    output bpf_pkg::t_in_beat     o_beat
);
    import bpf_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    assign s_axis_tready = !r_valid || i_take;
    assign o_valid       = r_valid;
    assign o_beat        = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_beat <= i_beat;
        end
    end

endmodule

`default_nettype wire

>>> sv/bpf_match.sv
`default_nettype none

module bpf_match (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [bpf_pkg::BYTE_W-1:0]  i_byte,
    input  wire bpf_pkg::t_window            i_pattern,
    input  wire logic [bpf_pkg::LEN_W-1:0]   i_len,
    output logic                             o_equal
);
    import bpf_pkg::*;

    t_window r_win;
    t_window n_win;

    always_comb begin
        n_win[0] = i_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    // Pattern byte 0 lines up with the oldest byte of the candidate match.
    always_comb begin
        logic [LEN_W-1:0] idx;
        o_equal = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            idx = i_len - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < i_len && i_pattern[i] != n_win[idx[IDX_W-1:0]]) begin
                o_equal = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_step) begin
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire
